/* hw/rtl/ssad_pkg.sv */
// ssad_pkg: shared types, constants and the elaboration-time trig function for the
// spatial sound angle/distance block. No dependencies.
package ssad_pkg;

  localparam int ANGLE_W = 9;
  localparam int LEVEL_W = 8;
  localparam int SCALE_W = 16;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd255;

  localparam int TAB_N = 45;
  localparam int SIDX_W = $clog2(TAB_N);
  localparam int TRIG_FRAC = 40;
  localparam int TRIG_W = TRIG_FRAC + 1;

  localparam logic [ANGLE_W-1:0] DEG_EQ = 9'd45;
  localparam logic [ANGLE_W-1:0] DEG_OCT_TOP = 9'd89;
  localparam logic [ANGLE_W-1:0] DEG_Q1 = 9'd90;
  localparam logic [ANGLE_W-1:0] DEG_Q2 = 9'd180;
  localparam logic [ANGLE_W-1:0] DEG_Q3 = 9'd270;
  localparam logic [ANGLE_W-1:0] DEG_FULL = 9'd360;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [1:0] MODE_LT = 2'd0;
  localparam logic [1:0] MODE_EQ = 2'd1;
  localparam logic [1:0] MODE_GT = 2'd2;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [127:0] ONE_Q62 = 128'd1 << 62;

  typedef struct packed {
    logic       zero;
    logic       huge;
    logic [1:0] quad;
    logic [1:0] mode;
  } cls_t;

  function automatic logic [127:0] mul_q62(input logic [127:0] a, input logic [127:0] b);
    logic [127:0] p;
    p = a * b;
    return p >> 62;
  endfunction

  // sin/cos of k degrees, Q40, from a one-degree rotation applied k times
  function automatic logic [TRIG_W-1:0] trig_q40(input int k, input logic want_sin);
    logic [127:0] x, x2, s, c, t, ps, pc, ns;
    int n;
    x = {64'd0, PI_Q60} / 128'd45;
    x2 = mul_q62(x, x);
    s = x;
    c = ONE_Q62;
    t = x;
    for (n = 1; n <= 8; n++) begin
      t = mul_q62(t, x2);
      case (n)
        1: t = t / 128'd6;
        2: t = t / 128'd20;
        3: t = t / 128'd42;
        4: t = t / 128'd72;
        5: t = t / 128'd110;
        6: t = t / 128'd156;
        7: t = t / 128'd210;
        default: t = t / 128'd272;
      endcase
      s = (n % 2 == 1) ? s - t : s + t;
    end
    t = ONE_Q62;
    for (n = 1; n <= 8; n++) begin
      t = mul_q62(t, x2);
      case (n)
        1: t = t / 128'd2;
        2: t = t / 128'd12;
        3: t = t / 128'd30;
        4: t = t / 128'd56;
        5: t = t / 128'd90;
        6: t = t / 128'd132;
        7: t = t / 128'd182;
        default: t = t / 128'd240;
      endcase
      c = (n % 2 == 1) ? c - t : c + t;
    end
    ps = '0;
    pc = ONE_Q62;
    for (n = 1; n <= k; n++) begin
      ns = mul_q62(ps, c) + mul_q62(pc, s);
      pc = mul_q62(pc, c) - mul_q62(ps, s);
      ps = ns;
    end
    return want_sin ? TRIG_W'(ps >> (62 - TRIG_FRAC)) : TRIG_W'(pc >> (62 - TRIG_FRAC));
  endfunction

endpackage

/* hw/rtl/ssad_item_if.sv */
// ssad_item_if: input channel, listener and source coordinates.
// Depends on nothing.
interface ssad_item_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] listener_x;
  logic signed [COORD_WIDTH-1:0] listener_y;
  logic signed [COORD_WIDTH-1:0] source_x;
  logic signed [COORD_WIDTH-1:0] source_y;

  modport source (output valid, listener_x, listener_y, source_x, source_y, input ready);
  modport sink (input valid, listener_x, listener_y, source_x, source_y, output ready);
endinterface

/* hw/rtl/ssad_result_if.sv */
// ssad_result_if: result channel, angle, distance level and clamp flag.
// Depends on nothing.
interface ssad_result_if;
  logic       valid;
  logic       ready;
  logic [8:0] angle_deg;
  logic [7:0] distance_level;
  logic       clamped;

  modport source (output valid, angle_deg, distance_level, clamped, input ready);
  modport sink (input valid, angle_deg, distance_level, clamped, output ready);
endinterface

/* hw/rtl/ssad_front.sv */
// ssad_front: accepts coordinate beats, forms the difference vector and
// classifies it (quadrant, octant side). Uses ssad_pkg, ssad_item_if.
module ssad_front import ssad_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  ssad_item_if.sink              item,
  input  logic                   full,
  output logic                   push,
  output cls_t                   cls,
  output logic [COORD_WIDTH-1:0] num,
  output logic [COORD_WIDTH-1:0] den,
  output logic [COORD_WIDTH-1:0] adx,
  output logic [COORD_WIDTH-1:0] ady
);

  logic signed [COORD_WIDTH:0] dx, dy;
  logic [COORD_WIDTH:0] adx_w, ady_w;
  logic [COORD_WIDTH-1:0] a, b;
  logic [32:0] adx_x, ady_x;

  assign item.ready = !full;
  assign push = item.valid && !full;

  always_comb begin
    dx = $signed({item.listener_x[COORD_WIDTH-1], item.listener_x})
       - $signed({item.source_x[COORD_WIDTH-1], item.source_x});
    dy = $signed({item.listener_y[COORD_WIDTH-1], item.listener_y})
       - $signed({item.source_y[COORD_WIDTH-1], item.source_y});
    adx_w = dx[COORD_WIDTH] ? $unsigned(-dx) : $unsigned(dx);
    ady_w = dy[COORD_WIDTH] ? $unsigned(-dy) : $unsigned(dy);
    adx = adx_w[COORD_WIDTH-1:0];
    ady = ady_w[COORD_WIDTH-1:0];
    adx_x = 33'(adx);
    ady_x = 33'(ady);

    cls.zero = (dx == '0) && (dy == '0);
    cls.huge = (adx_x >= 33'h20000) || (ady_x >= 33'h20000);
    if (dy > 0 && dx <= 0) begin
      cls.quad = QUAD_0;
    end else if (dy <= 0 && dx < 0) begin
      cls.quad = QUAD_1;
    end else if (dy < 0 && dx >= 0) begin
      cls.quad = QUAD_2;
    end else begin
      cls.quad = QUAD_3;
    end

    // rotated vector (a, b): a > 0 (a = 0 only for the zero vector), b >= 0
    if (cls.quad == QUAD_0 || cls.quad == QUAD_2) begin
      a = ady;
      b = adx;
    end else begin
      a = adx;
      b = ady;
    end

    if (b < a) begin
      cls.mode = MODE_LT;
      num = b;
      den = a;
    end else if (b == a) begin
      cls.mode = MODE_EQ;
      num = b;
      den = a;
    end else begin
      cls.mode = MODE_GT;
      num = a;
      den = b;
    end
  end

endmodule

/* hw/rtl/ssad_queue.sv */
// ssad_queue: small FIFO between front and back ends.
// No dependencies.
module ssad_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/ssad_back.sv */
// ssad_back: pipelined angle search, square root and scaling divider,
// plus the distance_scale register. Uses ssad_pkg, ssad_result_if.
module ssad_back import ssad_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_LEVEL = 255
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   scale_we,
  input  logic [SCALE_W-1:0]     scale_wdata,
  input  logic                   head_valid,
  input  cls_t                   cls,
  input  logic [COORD_WIDTH-1:0] num,
  input  logic [COORD_WIDTH-1:0] den,
  input  logic [COORD_WIDTH-1:0] adx,
  input  logic [COORD_WIDTH-1:0] ady,
  output logic                   pop,
  ssad_result_if.source          result
);

  localparam int CW = COORD_WIDTH;
  localparam int RW = CW + 1;
  localparam int SW = 2 * RW;
  localparam int REMW = RW + 3;
  localparam int LW = $clog2(MAX_LEVEL + 1);
  localparam int NW = RW + LW;
  localparam int DIVW = NW + SCALE_W;
  localparam int PW = CW + TRIG_W;
  localparam int S_ANG = 2 * SIDX_W;
  localparam int S_SUM = S_ANG + 1;
  localparam int S_ROOT0 = S_SUM + 1;
  localparam int S_PROD = S_ROOT0 + RW;
  localparam int S_SAT = S_PROD + 1;
  localparam int S_DIV0 = S_SAT + 1;
  localparam int NST = S_DIV0 + LW;

  typedef struct packed {
    cls_t               cls;
    logic [CW-1:0]      num;
    logic [CW-1:0]      den;
    logic [CW-1:0]      adx;
    logic [CW-1:0]      ady;
    logic [SIDX_W-1:0]  lo;
    logic [SIDX_W-1:0]  cand;
    logic               ok;
    logic [PW-1:0]      p1;
    logic [PW-1:0]      p2;
    logic [ANGLE_W-1:0] angle;
    logic [2*CW-1:0]    sqx;
    logic [2*CW-1:0]    sqy;
    logic [SW-1:0]      rad;
    logic [REMW-1:0]    rem;
    logic [RW-1:0]      root;
    logic [NW-1:0]      prod;
    logic               sat;
    logic [DIVW-1:0]    drem;
    logic [LW-1:0]      q;
  } stage_t;

  logic [TRIG_W-1:0] sin_t [TAB_N];
  logic [TRIG_W-1:0] cos_t [TAB_N];
  logic [SCALE_W-1:0] scale;
  logic [DIVW-1:0] lim;
  logic scale_zero;
  stage_t st [NST+1];
  stage_t nx [NST];
  logic vld [NST+1];
  logic en;

  for (genvar k = 0; k < TAB_N; k++) begin : g_tab
    assign sin_t[k] = trig_q40(k, 1'b1);
    assign cos_t[k] = trig_q40(k, 1'b0);
  end

  // (MAX_LEVEL+1)*scale: quotient above MAX_LEVEL iff dist*MAX_LEVEL >= lim
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
      lim <= DIVW'(SCALE_RESET) * DIVW'(MAX_LEVEL + 1);
      scale_zero <= 1'b0;
    end else if (scale_we) begin
      scale <= scale_wdata;
      lim <= DIVW'(scale_wdata) * DIVW'(MAX_LEVEL + 1);
      scale_zero <= (scale_wdata == '0);
    end
  end

  assign en = !vld[NST] || result.ready;
  assign pop = en && head_valid;
  assign vld[0] = head_valid;

  always_comb begin
    st[0] = '0;
    st[0].cls = cls;
    st[0].num = num;
    st[0].den = den;
    st[0].adx = adx;
    st[0].ady = ady;
  end

  for (genvar i = 0; i < NST; i++) begin : g_stage
    if (i < S_ANG && i % 2 == 0) begin : g_srch_mul
      localparam int B = SIDX_W - 1 - i / 2;
      logic [SIDX_W-1:0] idx;
      always_comb begin
        nx[i] = st[i];
        nx[i].cand = st[i].lo + SIDX_W'(1 << B);
        nx[i].ok = (nx[i].cand <= SIDX_W'(TAB_N - 1));
        idx = nx[i].ok ? nx[i].cand : '0;
        nx[i].p1 = {{TRIG_W{1'b0}}, st[i].num} * {{CW{1'b0}}, cos_t[idx]};
        nx[i].p2 = {{TRIG_W{1'b0}}, st[i].den} * {{CW{1'b0}}, sin_t[idx]};
      end
    end else if (i < S_ANG) begin : g_srch_cmp
      always_comb begin
        nx[i] = st[i];
        if (st[i].ok && st[i].p1 >= st[i].p2) begin
          nx[i].lo = st[i].cand;
        end
      end
    end else if (i == S_ANG) begin : g_angle
      logic [ANGLE_W-1:0] f, base;
      always_comb begin
        nx[i] = st[i];
        case (st[i].cls.mode)
          MODE_LT: f = ANGLE_W'(st[i].lo);
          MODE_EQ: f = DEG_EQ;
          MODE_GT: f = DEG_OCT_TOP - ANGLE_W'(st[i].lo);
          default: f = '0;
        endcase
        case (st[i].cls.quad)
          QUAD_0: base = '0;
          QUAD_1: base = DEG_Q1;
          QUAD_2: base = DEG_Q2;
          QUAD_3: base = DEG_Q3;
          default: base = '0;
        endcase
        nx[i].angle = st[i].cls.zero ? '0 : base + f;
        nx[i].sqx = {{CW{1'b0}}, st[i].adx} * {{CW{1'b0}}, st[i].adx};
        nx[i].sqy = {{CW{1'b0}}, st[i].ady} * {{CW{1'b0}}, st[i].ady};
      end
    end else if (i == S_SUM) begin : g_sum
      always_comb begin
        nx[i] = st[i];
        nx[i].rad = SW'(st[i].sqx) + SW'(st[i].sqy);
        nx[i].rem = '0;
        nx[i].root = '0;
      end
    end else if (i < S_PROD) begin : g_root
      localparam int T = i - S_ROOT0;
      logic [REMW-1:0] r2, trial;
      always_comb begin
        nx[i] = st[i];
        r2 = {st[i].rem[REMW-3:0], st[i].rad[SW-1-2*T -: 2]};
        trial = {1'b0, st[i].root, 2'b01};
        if (r2 >= trial) begin
          nx[i].rem = r2 - trial;
          nx[i].root = {st[i].root[RW-2:0], 1'b1};
        end else begin
          nx[i].rem = r2;
          nx[i].root = {st[i].root[RW-2:0], 1'b0};
        end
      end
    end else if (i == S_PROD) begin : g_prod
      always_comb begin
        nx[i] = st[i];
        nx[i].prod = {{LW{1'b0}}, st[i].root} * NW'(MAX_LEVEL);
      end
    end else if (i == S_SAT) begin : g_sat
      always_comb begin
        nx[i] = st[i];
        nx[i].sat = st[i].cls.huge || scale_zero || (DIVW'(st[i].prod) >= lim);
        nx[i].drem = DIVW'(st[i].prod);
        nx[i].q = '0;
      end
    end else begin : g_div
      localparam int B = LW - 1 - (i - S_DIV0);
      logic [DIVW-1:0] sh;
      always_comb begin
        nx[i] = st[i];
        sh = DIVW'(scale) << B;
        if (st[i].drem >= sh) begin
          nx[i].drem = st[i].drem - sh;
          nx[i].q[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nx[i];
      end
    end
  end

  assign result.valid = vld[NST];
  assign result.angle_deg = st[NST].angle;
  assign result.distance_level = st[NST].sat ? LEVEL_W'(MAX_LEVEL) : LEVEL_W'(st[NST].q);
  assign result.clamped = st[NST].sat;

endmodule

/* hw/rtl/spatial_sound_angle_distance.sv */
// spatial_sound_angle_distance: top level, front classifier, queue and back
// pipeline. Uses ssad_pkg, ssad_item_if, ssad_result_if, ssad_front/queue/back.
//
//   channel          dir  beat
//   item             in   listener_x, listener_y, source_x, source_y
//   result           out  angle_deg, distance_level, clamped
//   distance_scale   in   write when distance_scale_we is high
//
// One item per cycle sustained while result.ready stays high. The back pipeline has
// 12 + 4 + (COORD_WIDTH+1) + log2(MAX_LEVEL+1) stages (41 at defaults),
// set by the bit-serial square root and divider stages.
// Synchronous reset; distance_scale resets to 255.
// A stalled result freezes the back pipeline; the queue holds QUEUE_DEPTH items
// before item.ready drops.
module spatial_sound_angle_distance import ssad_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_LEVEL = 255,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  ssad_item_if.sink          item,
  ssad_result_if.source      result,
  input  logic               distance_scale_we,
  input  logic [SCALE_W-1:0] distance_scale
);

  localparam int CW = COORD_WIDTH;
  localparam int QW = $bits(cls_t) + 4 * CW;

  logic push, pop, full, empty;
  cls_t f_cls, b_cls;
  logic [CW-1:0] f_num, f_den, f_adx, f_ady;
  logic [CW-1:0] b_num, b_den, b_adx, b_ady;
  logic [QW-1:0] q_din, q_dout;

  ssad_front #(.COORD_WIDTH(CW)) u_front (
    .item (item),
    .full (full),
    .push (push),
    .cls  (f_cls),
    .num  (f_num),
    .den  (f_den),
    .adx  (f_adx),
    .ady  (f_ady)
  );

  assign q_din = {f_cls, f_num, f_den, f_adx, f_ady};

  ssad_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .full  (full),
    .pop   (pop),
    .dout  (q_dout),
    .empty (empty)
  );

  assign {b_cls, b_num, b_den, b_adx, b_ady} = q_dout;

  ssad_back #(.COORD_WIDTH(CW), .MAX_LEVEL(MAX_LEVEL)) u_back (
    .clk         (clk),
    .rst         (rst),
    .scale_we    (distance_scale_we),
    .scale_wdata (distance_scale),
    .head_valid  (!empty),
    .cls         (b_cls),
    .num         (b_num),
    .den         (b_den),
    .adx         (b_adx),
    .ady         (b_ady),
    .pop         (pop),
    .result      (result)
  );

`ifndef SYNTHESIS
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.angle_deg < DEG_FULL)
    else $error("angle out of range");

  a_clamp_level: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.clamped |-> result.distance_level == LEVEL_W'(MAX_LEVEL))
    else $error("clamped result not saturated");

  a_full_stalled: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> result.valid)
    else $error("queue full without output stall");
`endif

endmodule
